>>> hw/rtl/smsa_pkg.sv
`timescale 1ns / 1ps

package smsa_pkg;

   localparam int SAMPLE_W = 8;
   localparam int VALUE_W  = 8;
   localparam int INDEX_W  = 12;
   localparam int SEL_W    = 6;
   localparam int RSP_TDATA_W = 32;

   // scan position carried along with one finished point
   typedef struct packed {
      logic [INDEX_W-1:0] point_index;
      logic [SEL_W-1:0]   row_select;
      logic               column_change;
      logic [SEL_W-1:0]   column_select;
      logic               frame_end;
   } point_info_type;

endpackage

>>> hw/rtl/smsa_avg_out.sv
`timescale 1ns / 1ps

module smsa_avg_out #(
   parameter int SAMPLES_PER_POINT = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  pt_valid,
   output logic                                  pt_ready,
   input  logic [((SAMPLES_PER_POINT > 1) ? $clog2(SAMPLES_PER_POINT) : 1)
                 + smsa_pkg::SAMPLE_W - 1:0]     pt_sum,
   input  smsa_pkg::point_info_type              pt_info,
   input  logic [smsa_pkg::VALUE_W-1:0]          zero_level,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // point_value[7:0], point_index[19:8], row_select[25:20], column_select[31:26]
   output logic [smsa_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   // column_change[0]
   output logic                                  rsp_tuser,
   output logic                                  rsp_tlast
);

   localparam int CNT_W  = (SAMPLES_PER_POINT > 1) ? $clog2(SAMPLES_PER_POINT) : 1;
   localparam int SUM_W  = CNT_W + smsa_pkg::SAMPLE_W;
   localparam int LOG_D  = (SAMPLES_PER_POINT > 1) ? $clog2(SAMPLES_PER_POINT) : 0;
   // floor(n / D) == (n * RECIP) >> SHIFT for every n below 2**SUM_W
   localparam int SHIFT  = SUM_W + LOG_D;
   localparam int RECIP  = ((2 ** SHIFT) + SAMPLES_PER_POINT - 1) / SAMPLES_PER_POINT;
   localparam int MULT_W = SUM_W + 2;
   localparam int PROD_W = SUM_W + MULT_W;

   logic [PROD_W-1:0]            prod;
   logic [smsa_pkg::VALUE_W-1:0] avg;
   logic [smsa_pkg::VALUE_W-1:0] value;
   logic                         load;

   logic                         valid_ff;
   logic [smsa_pkg::VALUE_W-1:0] value_ff, value_in;
   smsa_pkg::point_info_type     info_ff, info_in;

   assign prod  = PROD_W'(pt_sum) * PROD_W'(MULT_W'(RECIP));
   assign avg   = prod[SHIFT +: smsa_pkg::VALUE_W];
   assign value = (avg > zero_level) ? (avg - zero_level) : '0;

   assign pt_ready = !valid_ff || rsp_tready;
   assign load     = pt_valid && pt_ready;
   assign value_in = value;
   assign info_in  = pt_info;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pt_ready) begin
         valid_ff <= pt_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         value_ff <= value_in;
         info_ff  <= info_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {info_ff.column_select, info_ff.row_select,
                        info_ff.point_index, value_ff};
   assign rsp_tuser  = info_ff.column_change;
   assign rsp_tlast  = info_ff.frame_end;

endmodule

>>> hw/rtl/sensor_matrix_scan_averager_top.sv
`timescale 1ns / 1ps
// Throughput: one sample per cycle while req_tready is high; one result per
// SAMPLES_PER_POINT samples, registered in a_sum_ff on a burst's last sample,
// then in smsa_avg_out's output register. The sample adder, then the reciprocal
// multiplier and clamp, each sit in one register stage, so nothing iterates.
// Reset (synchronous): clears sum, sample count, row/column/point counters,
// zero_level and all valid flags.
module sensor_matrix_scan_averager_top #(
   parameter int SAMPLES_PER_POINT = 16,
   parameter int ROWS              = 64,
   parameter int COLUMNS           = 64,
   parameter int POINTS            = 4096
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // sample[7:0]
   input  logic [7:0]                           req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // point_value[7:0], point_index[19:8], row_select[25:20], column_select[31:26]
   output logic [smsa_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   // column_change[0]
   output logic                                 rsp_tuser,
   output logic                                 rsp_tlast,
   input  logic                                 csr_we,
   input  logic [7:0]                           csr_wdata
);

   localparam int CNT_W = (SAMPLES_PER_POINT > 1) ? $clog2(SAMPLES_PER_POINT) : 1;
   localparam int SUM_W = CNT_W + smsa_pkg::SAMPLE_W;
   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int PT_W  = (POINTS > 1) ? $clog2(POINTS) : 1;

   logic [smsa_pkg::VALUE_W-1:0] zero_level_ff;

   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [PT_W-1:0]  pt_ff, pt_in;

   logic                     a_valid_ff, a_valid_in;
   logic [SUM_W-1:0]         a_sum_ff, a_sum_in;
   smsa_pkg::point_info_type a_info_ff, a_info_in;
   logic                     a_ready;

   logic             req_fire;
   logic             burst_done;
   logic [SUM_W-1:0] sum_total;
   logic [ROW_W:0]   row_plus;
   logic [COL_W:0]   col_plus;
   logic [PT_W:0]    pt_plus;
   logic             row_wrap;
   logic             col_wrap;
   logic             pt_wrap;
   logic [ROW_W-1:0] row_next;
   logic [COL_W-1:0] col_next;
   logic [PT_W-1:0]  pt_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_level_ff <= '0;
      end else if (csr_we) begin
         zero_level_ff <= csr_wdata;
      end
   end

   assign req_tready = !a_valid_ff || a_ready;
   assign req_fire   = req_tvalid && req_tready;
   assign burst_done = (cnt_ff == CNT_W'(SAMPLES_PER_POINT - 1));
   assign sum_total  = sum_ff + SUM_W'(req_tdata);

   assign row_plus = {1'b0, row_ff} + 1'b1;
   assign col_plus = {1'b0, col_ff} + 1'b1;
   assign pt_plus  = {1'b0, pt_ff} + 1'b1;
   assign row_wrap = (row_plus >= (ROW_W + 1)'(ROWS));
   assign col_wrap = (col_plus >= (COL_W + 1)'(COLUMNS));
   assign pt_wrap  = (pt_plus >= (PT_W + 1)'(POINTS));
   assign row_next = row_wrap ? '0 : row_plus[ROW_W-1:0];
   assign col_next = col_wrap ? '0 : col_plus[COL_W-1:0];
   assign pt_next  = pt_wrap ? '0 : pt_plus[PT_W-1:0];

   always_comb begin
      sum_in     = sum_ff;
      cnt_in     = cnt_ff;
      row_in     = row_ff;
      col_in     = col_ff;
      pt_in      = pt_ff;
      a_valid_in = a_valid_ff && !a_ready;
      a_sum_in   = sum_total;

      a_info_in.point_index   = smsa_pkg::INDEX_W'(pt_ff);
      a_info_in.row_select    = smsa_pkg::SEL_W'(row_next);
      a_info_in.column_change = row_wrap;
      a_info_in.column_select = row_wrap ? smsa_pkg::SEL_W'(col_ff) : '0;
      a_info_in.frame_end     = pt_wrap;

      if (req_fire) begin
         if (burst_done) begin
            sum_in     = '0;
            cnt_in     = '0;
            row_in     = row_next;
            col_in     = row_wrap ? col_next : col_ff;
            pt_in      = pt_next;
            a_valid_in = 1'b1;
         end else begin
            sum_in = sum_total;
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff     <= '0;
         cnt_ff     <= '0;
         row_ff     <= '0;
         col_ff     <= '0;
         pt_ff      <= '0;
         a_valid_ff <= 1'b0;
      end else begin
         sum_ff     <= sum_in;
         cnt_ff     <= cnt_in;
         row_ff     <= row_in;
         col_ff     <= col_in;
         pt_ff      <= pt_in;
         a_valid_ff <= a_valid_in;
      end
   end

   // point payload only moves on the transaction that closes a burst
   always_ff @(posedge clock) begin
      if (req_fire && burst_done) begin
         a_sum_ff  <= a_sum_in;
         a_info_ff <= a_info_in;
      end
   end

   smsa_avg_out #(
      .SAMPLES_PER_POINT (SAMPLES_PER_POINT)
   ) u_avg_out (
      .clock      (clock),
      .reset      (reset),
      .pt_valid   (a_valid_ff),
      .pt_ready   (a_ready),
      .pt_sum     (a_sum_ff),
      .pt_info    (a_info_ff),
      .zero_level (zero_level_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   a_counters_in_range: assert property (@(posedge clock) disable iff (reset)
      (ROW_W + 1)'(row_ff) < (ROW_W + 1)'(ROWS) &&
      (COL_W + 1)'(col_ff) < (COL_W + 1)'(COLUMNS) &&
      (PT_W + 1)'(pt_ff) < (PT_W + 1)'(POINTS))
      else $error("scan counter out of range");

   a_column_change_row_zero: assert property (@(posedge clock) disable iff (reset)
      a_valid_ff && a_info_ff.column_change |-> a_info_ff.row_select == '0)
      else $error("column change without row wrap");

   a_frame_end_last_point: assert property (@(posedge clock) disable iff (reset)
      a_valid_ff && a_info_ff.frame_end |->
         a_info_ff.point_index == smsa_pkg::INDEX_W'(POINTS - 1))
      else $error("frame end on wrong point");

   a_point_held_until_taken: assert property (@(posedge clock) disable iff (reset)
      a_valid_ff && !a_ready |=> a_valid_ff && $stable(a_sum_ff))
      else $error("pending point lost");

   a_burst_clears_sum: assert property (@(posedge clock) disable iff (reset)
      req_fire && burst_done |=> sum_ff == '0 && cnt_ff == '0)
      else $error("accumulator not cleared after burst");

endmodule

>>> tb/sv/sensor_matrix_scan_averager_top_tb.sv
`timescale 1ns / 1ps

module sensor_matrix_scan_averager_top_tb;

   localparam int SAMPLES_PER_POINT = 16;
   localparam int ROWS              = 64;
   localparam int COLUMNS           = 64;
   localparam int POINTS            = 4096;
   localparam int SETTLE_CYCLES     = 6;
   localparam int LONG_HOLD         = 300;
   localparam int WATCHDOG_LIMIT    = 2000;
   localparam int PRINT_LIMIT       = 40;

   typedef struct packed {
      logic [smsa_pkg::VALUE_W-1:0] value;
      smsa_pkg::point_info_type     info;
   } scan_point_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [7:0]                       req_tdata  = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   logic [smsa_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                             rsp_tuser;
   logic                             rsp_tlast;
   logic                             csr_we     = 1'b0;
   logic [7:0]                       csr_wdata  = '0;

   // stimulus and scoreboard
   logic [7:0]     sample_backlog[$];
   scan_point_type expected_points[$];
   int             samples_queued = 0;
   int             samples_taken  = 0;
   int             error_count    = 0;
   int             results_seen   = 0;

   // predictor state
   int burst_sum         = 0;
   int burst_len         = 0;
   int row_pos           = 0;
   int col_pos           = 0;
   int point_pos         = 0;
   int zero_level_shadow = 0;

   // idling
   int   req_pause  = 0;
   int   req_streak = 0;
   bit   req_calm   = 1'b0;
   int   rsp_pause  = 0;
   int   rsp_streak = 0;
   bit   rsp_calm   = 1'b0;
   logic ready_q    = 1'b0;
   logic hold_arm   = 1'b0;
   logic hold_done  = 1'b0;
   int   hold_count = 0;
   int   stuck_cycles = 0;

   always #5 clock = ~clock;

   assign rsp_tready = ready_q && !(hold_arm && !hold_done);

   sensor_matrix_scan_averager_top #(
      .SAMPLES_PER_POINT(SAMPLES_PER_POINT),
      .ROWS             (ROWS),
      .COLUMNS          (COLUMNS),
      .POINTS           (POINTS)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // Alternates stretches of random gaps with stretches of none.
   function automatic int next_pause(inout int streak_left, inout bit calm);
      if (streak_left == 0) begin
         calm = ($urandom_range(0, 3) == 0);
         streak_left = $urandom_range(10, 60);
      end
      streak_left--;
      return calm ? 0 : $urandom_range(0, 3);
   endfunction

   // Accumulates one ADC sample; a finished burst yields one expected point.
   function automatic void absorb_sample(input logic [7:0] adc);
      scan_point_type pt;
      int mean;
      burst_sum = (burst_sum + adc) & 16'hFFFF;
      burst_len++;
      if (burst_len < SAMPLES_PER_POINT) return;
      mean = burst_sum / SAMPLES_PER_POINT;
      burst_sum = 0;
      burst_len = 0;
      pt.value = (mean <= zero_level_shadow) ? '0 :
                 smsa_pkg::VALUE_W'(mean - zero_level_shadow);
      row_pos = (row_pos + 1) % ROWS;
      pt.info.column_change = (row_pos == 0);
      pt.info.column_select = '0;
      if (row_pos == 0) begin
         pt.info.column_select = smsa_pkg::SEL_W'(col_pos);
         col_pos = (col_pos + 1) % COLUMNS;
      end
      pt.info.row_select  = smsa_pkg::SEL_W'(row_pos);
      pt.info.point_index = smsa_pkg::INDEX_W'(point_pos);
      point_pos++;
      pt.info.frame_end = (point_pos >= POINTS);
      if (point_pos >= POINTS) point_pos = 0;
      expected_points.push_back(pt);
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      error_count++;
      if (error_count <= PRINT_LIMIT)
         $display("MISMATCH %s: got %0d, expected %0d (result %0d, t=%0t)",
                  what, got, want, results_seen, $time);
   endtask

   // sample driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_pause  <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            absorb_sample(req_tdata);
            samples_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (req_pause != 0) begin
               req_pause  <= req_pause - 1;
               req_tvalid <= 1'b0;
            end else if (sample_backlog.size() != 0) begin
               req_tdata  <= sample_backlog.pop_front();
               req_tvalid <= 1'b1;
               req_pause  <= next_pause(req_streak, req_calm);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // point monitor
   always @(posedge clock) begin : point_monitor
      scan_point_type want;
      int p;
      if (reset) begin
         ready_q   <= 1'b0;
         rsp_pause <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (expected_points.size() == 0) begin
            report_mismatch("unexpected transaction, point_index", rsp_tdata[19:8], -1);
         end else begin
            want = expected_points.pop_front();
            if (rsp_tdata[7:0] != want.value)
               report_mismatch("point_value", rsp_tdata[7:0], want.value);
            if (rsp_tdata[19:8] != want.info.point_index)
               report_mismatch("point_index", rsp_tdata[19:8], want.info.point_index);
            if (rsp_tdata[25:20] != want.info.row_select)
               report_mismatch("row_select", rsp_tdata[25:20], want.info.row_select);
            if (rsp_tdata[31:26] != want.info.column_select)
               report_mismatch("column_select", rsp_tdata[31:26], want.info.column_select);
            if (rsp_tuser != want.info.column_change)
               report_mismatch("column_change", rsp_tuser, want.info.column_change);
            if (rsp_tlast != want.info.frame_end)
               report_mismatch("frame_end", rsp_tlast, want.info.frame_end);
         end
         p = next_pause(rsp_streak, rsp_calm);
         ready_q   <= (p == 0);
         rsp_pause <= p;
      end else if (rsp_pause != 0) begin
         ready_q   <= (rsp_pause == 1);
         rsp_pause <= rsp_pause - 1;
      end else begin
         ready_q <= 1'b1;
      end
   end

   // one long receiver stall, armed by the stimulus
   always @(posedge clock) begin
      if (reset) begin
         hold_count <= 0;
         hold_done  <= 1'b0;
      end else if (hold_arm && !hold_done) begin
         if (hold_count == LONG_HOLD - 1) hold_done <= 1'b1;
         hold_count <= hold_count + 1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles == WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   task automatic queue_adc(input logic [7:0] adc);
      sample_backlog.push_back(adc);
      samples_queued++;
   endtask

   // One burst of random content, sometimes followed by a stray partial burst.
   task automatic queue_burst(input logic [7:0] lvl);
      logic [7:0] base;
      int style;
      style = $urandom_range(0, 5);
      base  = 8'($urandom_range(0, 255));
      // land the average just below, on, or just above the zero level
      if (style == 2) base = 8'(lvl + $urandom_range(0, 2) - 1);
      for (int k = 0; k < SAMPLES_PER_POINT; k++) begin
         case (style)
            0, 1:    queue_adc(8'($urandom_range(0, 255)));
            2, 3:    queue_adc(base);
            4:       queue_adc($urandom_range(0, 1) ? 8'hFF : 8'h00);
            default: queue_adc(8'(base + $urandom_range(0, 15)));
         endcase
      end
      if ($urandom_range(0, 7) == 0)
         repeat ($urandom_range(1, SAMPLES_PER_POINT - 1))
            queue_adc(8'($urandom_range(0, 255)));
   endtask

   // Waits until nothing is in flight before writing the zero level.
   task automatic set_zero_level(input logic [7:0] lvl);
      while (samples_taken != samples_queued || expected_points.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= lvl;
      @(posedge clock);
      zero_level_shadow = lvl;
      csr_we <= 1'b0;
   endtask

   initial begin : stimulus
      int plan[8] = '{255, 0, 128, -1, 1, 254, -1, -1};
      logic [7:0] lvl;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // full-scale burst at the reset zero level, then an unfinished burst
      repeat (SAMPLES_PER_POINT) queue_adc(8'hFF);
      repeat (8) queue_adc(8'h00);

      foreach (plan[i]) begin
         lvl = (plan[i] < 0) ? 8'($urandom_range(0, 255)) : 8'(plan[i]);
         set_zero_level(lvl);
         if (i == 3) begin
            // receiver stalls while samples keep coming, backing up the block
            @(posedge clock);
            hold_arm <= 1'b1;
            repeat (25) queue_burst(lvl);
         end else begin
            repeat (9) queue_burst(lvl);
         end
      end

      while (samples_taken != samples_queued || expected_points.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
